// ----- src/object_cache_promote_lru_policy_unit_defines.svh -----
// assertion macros for the object cache promote lru policy unit
// used by the top level, which must have clk and arst_n in scope
`ifndef OBJECT_CACHE_PROMOTE_LRU_POLICY_UNIT_DEFINES_SVH
`define OBJECT_CACHE_PROMOTE_LRU_POLICY_UNIT_DEFINES_SVH

// plain clocked check, off while reset is asserted
`define OCLRU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication form built on the plain check
`define OCLRU_ASSERT_IMP(lbl, ante, cons, msg) \
	`OCLRU_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- src/oclru_pkg.sv -----
// shared constants, codes and controller/datapath types for the lru policy unit
// no dependencies
package oclru_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int MAX_POP         = 64;
	localparam int KEY_W           = 64;

	// request codes
	localparam logic [2:0] REQ_LOOKUP     = 3'd0;
	localparam logic [2:0] REQ_SET_STATUS = 3'd1;
	localparam logic [2:0] REQ_EVICT      = 3'd2;
	localparam logic [2:0] REQ_EVICT_LIST = 3'd3;
	localparam logic [2:0] REQ_QUERY      = 3'd4;

	// slot status codes
	localparam logic [1:0] ST_FREE      = 2'd0;
	localparam logic [1:0] ST_PROMOTING = 2'd1;
	localparam logic [1:0] ST_PROMOTED  = 2'd2;
	localparam logic [1:0] ST_SKIP      = 2'd1;

	// configuration register indexes
	localparam logic [1:0] CFG_ACTIVE_ENTRIES = 2'd0;
	localparam logic [1:0] CFG_WATERMARK      = 2'd1;
	localparam logic [1:0] CFG_EVICT_BATCH    = 2'd2;

	localparam logic [6:0] ACTIVE_RST = 7'd64;
	localparam logic [8:0] WMARK_RST  = 9'd26;
	localparam logic [6:0] BATCH_RST  = 7'd10;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_CLEAR,
		DP_FIND,
		DP_RANK,
		DP_WRITE,
		DP_POP
	} dp_op_t;

	typedef enum logic [1:0] {
		RK_INC_ALL,
		RK_INC_LT,
		RK_DEC_GT
	} rank_mode_t;

	typedef struct packed {
		logic       start;
		dp_op_t     op;
		rank_mode_t mode;
		logic       key_we;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic free_found;
		logic pop_found;
	} dp_sts_t;

endpackage

// ----- src/oclru_req_if.sv -----
// request channel: valid/ready handshake with the request fields
// depends on oclru_pkg
interface oclru_req_if import oclru_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       req_type;
	logic [KEY_W-1:0] object_key;
	logic [1:0]       next_status;

	modport source (output valid, req_type, object_key, next_status, input ready);
	modport sink (input valid, req_type, object_key, next_status, output ready);
endinterface

// ----- src/oclru_rsp_if.sv -----
// response channel: valid/ready handshake with the result fields
// depends on oclru_pkg
interface oclru_rsp_if import oclru_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [KEY_W-1:0] victim_key;
	logic             victim_valid;
	logic             last;
	logic [6:0]       free_count;
	logic [6:0]       promoted_count;

	modport source (output valid, status, victim_key, victim_valid, last, free_count,
		promoted_count, input ready);
	modport sink (input valid, status, victim_key, victim_valid, last, free_count,
		promoted_count, output ready);
endinterface

// ----- src/object_cache_promote_lru_policy_unit.sv -----
// every request scans the slot table before its result is given;
// a request that moves lru ranks adds a second table pass
// evict list: each popped key costs one tail-search pass over the table
// requests are taken one at a time; the slot-by-slot table scan sets the pace
// reset: asynchronous; a clearing pass over the table runs before the first request is taken
`include "object_cache_promote_lru_policy_unit_defines.svh"
module object_cache_promote_lru_policy_unit import oclru_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int AW = $clog2(MAX_ENTRIES),
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata,
	oclru_req_if.sink   req,
	oclru_rsp_if.source rsp
);

	localparam int EW = (CW > 7) ? CW : 7;

	logic [6:0]       active_q;
	logic [8:0]       wmark_q;
	logic [6:0]       batch_q;
	logic [EW-1:0]    act_w;
	logic [CW-1:0]    eff_active;
	logic [6:0]       batch_eff;

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [KEY_W-1:0] key_bus;
	logic [AW-1:0]    tgt_idx;
	logic [1:0]       tgt_status;
	logic             tgt_in_lru;
	logic [AW-1:0]    tgt_rank;
	logic [AW-1:0]    ref_rank;
	logic [AW-1:0]    hit_idx;
	logic [1:0]       hit_status;
	logic             hit_in_lru;
	logic [AW-1:0]    hit_rank;
	logic [AW-1:0]    free_idx;
	logic [CW-1:0]    free_cnt;
	logic [AW-1:0]    pop_idx;
	logic [KEY_W-1:0] pop_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
			wmark_q  <= WMARK_RST;
			batch_q  <= BATCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_ENTRIES: active_q <= cfg_wdata[6:0];
				CFG_WATERMARK:      wmark_q  <= cfg_wdata;
				CFG_EVICT_BATCH:    batch_q  <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// zero acts as one slot, anything above the table size as the table size
	assign act_w      = EW'(active_q);
	assign eff_active = (active_q == 7'd0) ? CW'(1) :
		(act_w > EW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(act_w);
	assign batch_eff  = (batch_q > 7'(MAX_POP)) ? 7'(MAX_POP) : batch_q;

	oclru_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.eff_active (eff_active),
		.watermark  (wmark_q),
		.batch      (batch_eff),
		.cmd        (cmd),
		.sts        (sts),
		.key_out    (key_bus),
		.tgt_idx    (tgt_idx),
		.tgt_status (tgt_status),
		.tgt_in_lru (tgt_in_lru),
		.tgt_rank   (tgt_rank),
		.ref_rank   (ref_rank),
		.hit_idx    (hit_idx),
		.hit_status (hit_status),
		.hit_in_lru (hit_in_lru),
		.hit_rank   (hit_rank),
		.free_idx   (free_idx),
		.free_cnt   (free_cnt),
		.pop_idx    (pop_idx),
		.pop_key    (pop_key)
	);

	oclru_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.eff_active (eff_active),
		.key_in     (key_bus),
		.tgt_idx    (tgt_idx),
		.tgt_status (tgt_status),
		.tgt_in_lru (tgt_in_lru),
		.tgt_rank   (tgt_rank),
		.ref_rank   (ref_rank),
		.hit_idx    (hit_idx),
		.hit_status (hit_status),
		.hit_in_lru (hit_in_lru),
		.hit_rank   (hit_rank),
		.free_idx   (free_idx),
		.free_cnt   (free_cnt),
		.pop_idx    (pop_idx),
		.pop_key    (pop_key)
	);

	`OCLRU_ASSERT(a_one_side, !(req.ready && rsp.valid), "request taken while result pending")
	`OCLRU_ASSERT_IMP(a_victim_status, rsp.valid && rsp.victim_valid, rsp.status == ST_FREE, "victim with status")
	`OCLRU_ASSERT_IMP(a_burst_victims, rsp.valid && !rsp.last, rsp.victim_valid, "non-final result without victim")
	`OCLRU_ASSERT_IMP(a_free_bound, rsp.valid, rsp.free_count <= eff_active, "free count above active slots")

endmodule

// ----- src/oclru_dp.sv -----
// slot table datapath: key and meta memories, one-slot-per-cycle scan engine
// depends on oclru_pkg
module oclru_dp import oclru_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int AW = $clog2(MAX_ENTRIES),
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [CW-1:0]    eff_active,
	input  logic [KEY_W-1:0] key_in,
	input  logic [AW-1:0]    tgt_idx,
	input  logic [1:0]       tgt_status,
	input  logic             tgt_in_lru,
	input  logic [AW-1:0]    tgt_rank,
	input  logic [AW-1:0]    ref_rank,
	output logic [AW-1:0]    hit_idx,
	output logic [1:0]       hit_status,
	output logic             hit_in_lru,
	output logic [AW-1:0]    hit_rank,
	output logic [AW-1:0]    free_idx,
	output logic [CW-1:0]    free_cnt,
	output logic [AW-1:0]    pop_idx,
	output logic [KEY_W-1:0] pop_key
);

	localparam int MW = AW + 3;

	// meta word: status, in-lru flag, rank
	logic [MW-1:0]    meta_mem [MAX_ENTRIES];
	logic [KEY_W-1:0] key_mem [MAX_ENTRIES];

	logic             busy_q;
	dp_op_t           op_q;
	rank_mode_t       mode_q;
	logic [CW-1:0]    idx_q;
	logic             done_q;
	logic             v_s1;
	logic [AW-1:0]    addr_s1;
	logic [MW-1:0]    meta_s1;
	logic [KEY_W-1:0] key_s1;

	logic             hit_q;
	logic [AW-1:0]    hit_idx_q;
	logic [MW-1:0]    hit_meta_q;
	logic             free_found_q;
	logic [AW-1:0]    free_idx_q;
	logic [CW-1:0]    free_cnt_q;
	logic             pop_found_q;
	logic [AW-1:0]    pop_idx_q;
	logic [KEY_W-1:0] pop_key_q;

	logic             issue;
	logic             last_s1;
	logic             scan_start;
	logic             single_wr;
	logic [1:0]       st_s1;
	logic             lru_s1;
	logic [AW-1:0]    rank_s1;
	logic [AW-1:0]    new_rank;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [MW-1:0]    mem_wdata;

	assign issue      = busy_q && (idx_q != CW'(MAX_ENTRIES));
	assign last_s1    = v_s1 && (addr_s1 == AW'(MAX_ENTRIES - 1));
	assign single_wr  = cmd.start && (cmd.op == DP_WRITE);
	assign scan_start = cmd.start && (cmd.op == DP_CLEAR || cmd.op == DP_FIND ||
		cmd.op == DP_RANK || cmd.op == DP_POP);

	assign st_s1   = meta_s1[MW-1 -: 2];
	assign lru_s1  = meta_s1[AW];
	assign rank_s1 = meta_s1[AW-1:0];

	always_comb begin
		case (mode_q)
			RK_INC_ALL: new_rank = rank_s1 + AW'(1);
			RK_INC_LT:  new_rank = (rank_s1 < ref_rank) ? rank_s1 + AW'(1) : rank_s1;
			RK_DEC_GT:  new_rank = (rank_s1 > ref_rank) ? rank_s1 - AW'(1) : rank_s1;
			default:    new_rank = rank_s1;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = addr_s1;
		mem_wdata = meta_s1;
		if (single_wr) begin
			mem_we    = 1'b1;
			mem_addr  = tgt_idx;
			mem_wdata = {tgt_status, tgt_in_lru, tgt_rank};
		end else if (v_s1 && op_q == DP_CLEAR) begin
			mem_we    = 1'b1;
			mem_wdata = '0;
		end else if (v_s1 && op_q == DP_RANK && lru_s1) begin
			mem_we    = 1'b1;
			mem_wdata = {st_s1, 1'b1, new_rank};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			meta_mem[mem_addr] <= mem_wdata;
		end
		if (single_wr && cmd.key_we) begin
			key_mem[tgt_idx] <= key_in;
		end
		addr_s1 <= idx_q[AW-1:0];
		meta_s1 <= meta_mem[idx_q[AW-1:0]];
		key_s1  <= key_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			op_q         <= DP_NOP;
			mode_q       <= RK_INC_ALL;
			idx_q        <= '0;
			done_q       <= 1'b0;
			v_s1         <= 1'b0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			hit_meta_q   <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			free_cnt_q   <= '0;
			pop_found_q  <= 1'b0;
			pop_idx_q    <= '0;
			pop_key_q    <= '0;
		end else begin
			v_s1   <= issue;
			done_q <= last_s1;
			if (scan_start) begin
				busy_q       <= 1'b1;
				op_q         <= cmd.op;
				mode_q       <= cmd.mode;
				idx_q        <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				free_cnt_q   <= '0;
				pop_found_q  <= 1'b0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (last_s1) begin
					busy_q <= 1'b0;
				end
				if (v_s1 && op_q == DP_FIND) begin
					if (st_s1 != ST_FREE && key_s1 == key_in && !hit_q) begin
						hit_q      <= 1'b1;
						hit_idx_q  <= addr_s1;
						hit_meta_q <= meta_s1;
					end
					// only slots below the active count are free for use
					if (st_s1 == ST_FREE && CW'(addr_s1) < eff_active) begin
						free_cnt_q <= free_cnt_q + CW'(1);
						if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= addr_s1;
						end
					end
				end
				// lru tail is the entry whose rank is size minus one
				if (v_s1 && op_q == DP_POP && lru_s1 && rank_s1 == ref_rank &&
						!pop_found_q) begin
					pop_found_q <= 1'b1;
					pop_idx_q   <= addr_s1;
					pop_key_q   <= key_s1;
				end
			end
		end
	end

	assign sts.done       = done_q;
	assign sts.hit        = hit_q;
	assign sts.free_found = free_found_q;
	assign sts.pop_found  = pop_found_q;

	assign hit_idx    = hit_idx_q;
	assign hit_status = hit_meta_q[MW-1 -: 2];
	assign hit_in_lru = hit_meta_q[AW];
	assign hit_rank   = hit_meta_q[AW-1:0];
	assign free_idx   = free_idx_q;
	assign free_cnt   = free_cnt_q;
	assign pop_idx    = pop_idx_q;
	assign pop_key    = pop_key_q;

endmodule

// ----- src/oclru_ctrl.sv -----
// request sequencer: decodes requests, drives datapath passes, holds the result register
// depends on oclru_pkg and the request/response interfaces
module oclru_ctrl import oclru_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int AW = $clog2(MAX_ENTRIES),
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	oclru_req_if.sink        req,
	oclru_rsp_if.source      rsp,
	input  logic [CW-1:0]    eff_active,
	input  logic [8:0]       watermark,
	input  logic [6:0]       batch,
	output dp_cmd_t          cmd,
	input  dp_sts_t          sts,
	output logic [KEY_W-1:0] key_out,
	output logic [AW-1:0]    tgt_idx,
	output logic [1:0]       tgt_status,
	output logic             tgt_in_lru,
	output logic [AW-1:0]    tgt_rank,
	output logic [AW-1:0]    ref_rank,
	input  logic [AW-1:0]    hit_idx,
	input  logic [1:0]       hit_status,
	input  logic             hit_in_lru,
	input  logic [AW-1:0]    hit_rank,
	input  logic [AW-1:0]    free_idx,
	input  logic [CW-1:0]    free_cnt,
	input  logic [AW-1:0]    pop_idx,
	input  logic [KEY_W-1:0] pop_key
);

	typedef enum logic [2:0] {
		S_CLR_GO,
		S_CLR_WAIT,
		S_IDLE,
		S_FIND,
		S_DECIDE,
		S_RANK,
		S_POP,
		S_OUT
	} state_t;

	state_t           state_q;
	dp_cmd_t          cmd_q;
	logic [2:0]       req_type_q;
	logic [KEY_W-1:0] key_q;
	logic [1:0]       ns_q;
	logic [CW-1:0]    size_q;
	logic [CW-1:0]    fc_q;
	logic [6:0]       pop_cnt_q;
	logic [AW-1:0]    tgt_idx_q;
	logic [1:0]       tgt_status_q;
	logic             tgt_in_lru_q;
	logic [AW-1:0]    tgt_rank_q;
	logic [AW-1:0]    ref_rank_q;
	logic [1:0]       out_status_q;
	logic [KEY_W-1:0] out_key_q;
	logic             out_vv_q;
	logic             out_last_q;

	state_t           n_state;
	dp_cmd_t          n_cmd;
	logic [2:0]       n_req_type;
	logic [KEY_W-1:0] n_key;
	logic [1:0]       n_ns;
	logic [CW-1:0]    n_size;
	logic [CW-1:0]    n_fc;
	logic [6:0]       n_pop_cnt;
	logic [AW-1:0]    n_tgt_idx;
	logic [1:0]       n_tgt_status;
	logic             n_tgt_in_lru;
	logic [AW-1:0]    n_tgt_rank;
	logic [AW-1:0]    n_ref_rank;
	logic [1:0]       n_out_status;
	logic [KEY_W-1:0] n_out_key;
	logic             n_out_vv;
	logic             n_out_last;

	logic [1:0]       eff_ns;
	logic [CW+8:0]    wm_lhs;
	logic [CW+8:0]    wm_rhs;
	logic             ev_cond;

	assign eff_ns  = (req_type_q == REQ_EVICT) ? ST_FREE : ns_q;
	assign wm_lhs  = (CW+9)'({free_cnt, 8'd0});
	assign wm_rhs  = (CW+9)'(watermark) * (CW+9)'(eff_active);
	assign ev_cond = (wm_lhs < wm_rhs) && (batch != 7'd0) && (size_q != '0);

	always_comb begin
		n_state      = state_q;
		n_cmd        = cmd_q;
		n_cmd.start  = 1'b0;
		n_req_type   = req_type_q;
		n_key        = key_q;
		n_ns         = ns_q;
		n_size       = size_q;
		n_fc         = fc_q;
		n_pop_cnt    = pop_cnt_q;
		n_tgt_idx    = tgt_idx_q;
		n_tgt_status = tgt_status_q;
		n_tgt_in_lru = tgt_in_lru_q;
		n_tgt_rank   = tgt_rank_q;
		n_ref_rank   = ref_rank_q;
		n_out_status = out_status_q;
		n_out_key    = out_key_q;
		n_out_vv     = out_vv_q;
		n_out_last   = out_last_q;
		case (state_q)
			S_CLR_GO: begin
				n_cmd   = '{start: 1'b1, op: DP_CLEAR, mode: RK_INC_ALL, key_we: 1'b0};
				n_state = S_CLR_WAIT;
			end
			S_CLR_WAIT: begin
				if (sts.done) begin
					n_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					n_req_type = req.req_type;
					n_key      = req.object_key;
					n_ns       = req.next_status;
					n_cmd      = '{start: 1'b1, op: DP_FIND, mode: RK_INC_ALL,
						key_we: 1'b0};
					n_state    = S_FIND;
				end
			end
			S_FIND: begin
				if (sts.done) begin
					n_state = S_DECIDE;
				end
			end
			S_DECIDE: begin
				n_fc         = free_cnt;
				n_out_key    = '0;
				n_out_vv     = 1'b0;
				n_out_last   = 1'b1;
				n_out_status = ST_FREE;
				n_tgt_idx    = hit_idx;
				n_tgt_rank   = '0;
				n_state      = S_OUT;
				case (req_type_q)
					REQ_LOOKUP: begin
						if (sts.hit) begin
							n_out_status = hit_status;
							if (hit_status == ST_PROMOTED) begin
								n_tgt_status = ST_PROMOTED;
								n_tgt_in_lru = 1'b1;
								n_ref_rank   = hit_rank;
								n_state      = S_RANK;
								if (hit_in_lru) begin
									n_cmd = '{start: 1'b1, op: DP_RANK,
										mode: RK_INC_LT, key_we: 1'b0};
								end else begin
									// popped earlier: goes back on top
									n_cmd  = '{start: 1'b1, op: DP_RANK,
										mode: RK_INC_ALL, key_we: 1'b0};
									n_size = size_q + CW'(1);
								end
							end
						end else if (sts.free_found) begin
							n_tgt_idx    = free_idx;
							n_tgt_status = ST_PROMOTING;
							n_tgt_in_lru = 1'b0;
							n_fc         = free_cnt - CW'(1);
							n_cmd        = '{start: 1'b1, op: DP_WRITE,
								mode: RK_INC_ALL, key_we: 1'b1};
						end else begin
							n_out_status = ST_SKIP;
						end
					end
					REQ_SET_STATUS, REQ_EVICT: begin
						if (sts.hit) begin
							n_out_status = hit_status;
							if (hit_status == ST_PROMOTING && eff_ns == ST_PROMOTED) begin
								n_out_status = ST_PROMOTED;
								n_tgt_status = ST_PROMOTED;
								n_tgt_in_lru = 1'b1;
								n_size       = size_q + CW'(1);
								n_cmd        = '{start: 1'b1, op: DP_RANK,
									mode: RK_INC_ALL, key_we: 1'b0};
								n_state      = S_RANK;
							end else if (eff_ns == ST_FREE) begin
								n_out_status = ST_FREE;
								n_tgt_status = ST_FREE;
								n_tgt_in_lru = 1'b0;
								if (CW'(hit_idx) < eff_active) begin
									n_fc = free_cnt + CW'(1);
								end
								if (hit_in_lru) begin
									n_ref_rank = hit_rank;
									n_size     = size_q - CW'(1);
									n_cmd      = '{start: 1'b1, op: DP_RANK,
										mode: RK_DEC_GT, key_we: 1'b0};
									n_state    = S_RANK;
								end else begin
									n_cmd = '{start: 1'b1, op: DP_WRITE,
										mode: RK_INC_ALL, key_we: 1'b0};
								end
							end
						end
					end
					REQ_EVICT_LIST: begin
						if (ev_cond) begin
							n_pop_cnt  = '0;
							n_ref_rank = AW'(size_q - CW'(1));
							n_cmd      = '{start: 1'b1, op: DP_POP,
								mode: RK_INC_ALL, key_we: 1'b0};
							n_state    = S_POP;
						end
					end
					REQ_QUERY: begin
						if (sts.hit) begin
							n_out_status = hit_status;
						end
					end
					default: begin
						n_out_status = ST_FREE;
					end
				endcase
			end
			S_RANK: begin
				if (sts.done) begin
					n_cmd   = '{start: 1'b1, op: DP_WRITE, mode: RK_INC_ALL,
						key_we: 1'b0};
					n_state = S_OUT;
				end
			end
			S_POP: begin
				if (sts.done) begin
					n_out_status = ST_FREE;
					n_out_last   = 1'b1;
					n_state      = S_OUT;
					if (sts.pop_found) begin
						// popped entry stays promoted, leaves the lru order
						n_tgt_idx    = pop_idx;
						n_tgt_status = ST_PROMOTED;
						n_tgt_in_lru = 1'b0;
						n_tgt_rank   = '0;
						n_cmd        = '{start: 1'b1, op: DP_WRITE, mode: RK_INC_ALL,
							key_we: 1'b0};
						n_size       = size_q - CW'(1);
						n_pop_cnt    = pop_cnt_q + 7'd1;
						n_out_key    = pop_key;
						n_out_vv     = 1'b1;
						n_out_last   = (pop_cnt_q + 7'd1 == batch) || (size_q == CW'(1));
					end
				end
			end
			S_OUT: begin
				if (rsp.ready) begin
					if (req_type_q == REQ_EVICT_LIST && out_vv_q && !out_last_q) begin
						n_ref_rank = AW'(size_q - CW'(1));
						n_cmd      = '{start: 1'b1, op: DP_POP, mode: RK_INC_ALL,
							key_we: 1'b0};
						n_state    = S_POP;
					end else begin
						n_state = S_IDLE;
					end
				end
			end
			default: begin
				n_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR_GO;
			cmd_q        <= '{start: 1'b0, op: DP_NOP, mode: RK_INC_ALL, key_we: 1'b0};
			req_type_q   <= '0;
			key_q        <= '0;
			ns_q         <= '0;
			size_q       <= '0;
			fc_q         <= '0;
			pop_cnt_q    <= '0;
			tgt_idx_q    <= '0;
			tgt_status_q <= ST_FREE;
			tgt_in_lru_q <= 1'b0;
			tgt_rank_q   <= '0;
			ref_rank_q   <= '0;
			out_status_q <= ST_FREE;
			out_key_q    <= '0;
			out_vv_q     <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			state_q      <= n_state;
			cmd_q        <= n_cmd;
			req_type_q   <= n_req_type;
			key_q        <= n_key;
			ns_q         <= n_ns;
			size_q       <= n_size;
			fc_q         <= n_fc;
			pop_cnt_q    <= n_pop_cnt;
			tgt_idx_q    <= n_tgt_idx;
			tgt_status_q <= n_tgt_status;
			tgt_in_lru_q <= n_tgt_in_lru;
			tgt_rank_q   <= n_tgt_rank;
			ref_rank_q   <= n_ref_rank;
			out_status_q <= n_out_status;
			out_key_q    <= n_out_key;
			out_vv_q     <= n_out_vv;
			out_last_q   <= n_out_last;
		end
	end

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid          = (state_q == S_OUT);
	assign rsp.status         = out_status_q;
	assign rsp.victim_key     = out_key_q;
	assign rsp.victim_valid   = out_vv_q;
	assign rsp.last           = out_last_q;
	assign rsp.free_count     = (32'(fc_q) > 32'd127) ? 7'd127 : 7'(fc_q);
	assign rsp.promoted_count = (32'(size_q) > 32'd127) ? 7'd127 : 7'(size_q);

	assign cmd        = cmd_q;
	assign key_out    = key_q;
	assign tgt_idx    = tgt_idx_q;
	assign tgt_status = tgt_status_q;
	assign tgt_in_lru = tgt_in_lru_q;
	assign tgt_rank   = tgt_rank_q;
	assign ref_rank   = ref_rank_q;

endmodule

// ----- bench/object_cache_promote_lru_policy_unit_test.sv -----
// testbench for the object cache promote lru policy unit: random and directed requests,
// results checked against an in-bench model of the slot table and lru order
// depends on oclru_pkg, oclru_req_if, oclru_rsp_if and the unit itself
`timescale 1ns / 100ps
module object_cache_promote_lru_policy_unit_test;
	import oclru_pkg::*;

	localparam int SLOTS = 64;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int SETTLE = 2 * SLOTS + 80;

	typedef struct packed {
		logic [2:0]  rtype;
		logic [63:0] key;
		logic [1:0]  nstat;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] victim_key;
		logic        victim_valid;
		logic        last;
		logic [6:0]  free_count;
		logic [6:0]  promoted_count;
	} answer_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_wdata;

	oclru_req_if req_ch ();
	oclru_rsp_if rsp_ch ();

	object_cache_promote_lru_policy_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// model of the slot table
	logic [63:0] tbl_key [SLOTS];
	logic [1:0]  tbl_stat [SLOTS];
	int          tbl_rank [SLOTS];
	bit          tbl_in_lru [SLOTS];
	int          lru_count;
	int          m_active;
	int          m_wmark;
	int          m_batch;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	int       errors;
	int       cycles;
	int       accepted_reqs;
	int       checked_answers;
	int       victims_seen;
	bit       no_idle;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int eff_active();
		if (m_active == 0) return 1;
		if (m_active > SLOTS) return SLOTS;
		return m_active;
	endfunction

	function automatic int free_slots();
		int c;
		c = 0;
		for (int i = 0; i < eff_active(); i++)
			if (tbl_stat[i] == ST_FREE) c++;
		return c;
	endfunction

	function automatic int find_key(logic [63:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_stat[i] != ST_FREE && tbl_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void lru_to_top(int s);
		int r;
		if (tbl_in_lru[s]) begin
			r = tbl_rank[s];
			for (int j = 0; j < SLOTS; j++)
				if (tbl_in_lru[j] && tbl_rank[j] < r) tbl_rank[j]++;
		end else begin
			for (int j = 0; j < SLOTS; j++)
				if (tbl_in_lru[j]) tbl_rank[j]++;
			tbl_in_lru[s] = 1'b1;
			lru_count++;
		end
		tbl_rank[s] = 0;
	endfunction

	function automatic void lru_drop(int s);
		int r;
		if (!tbl_in_lru[s]) return;
		r = tbl_rank[s];
		tbl_in_lru[s] = 1'b0;
		tbl_rank[s] = 0;
		for (int j = 0; j < SLOTS; j++)
			if (tbl_in_lru[j] && tbl_rank[j] > r) tbl_rank[j]--;
		lru_count--;
	endfunction

	function automatic void push_answer(logic [1:0] st, logic [63:0] vk, logic vv, logic lst);
		answer_t a;
		int fc;
		int pc;
		fc = free_slots();
		pc = lru_count;
		a.status = st;
		a.victim_key = vk;
		a.victim_valid = vv;
		a.last = lst;
		a.free_count = (fc > 127) ? 7'd127 : 7'(fc);
		a.promoted_count = (pc > 127) ? 7'd127 : 7'(pc);
		expected_answers = {expected_answers, a};
	endfunction

	// works out the answers of one accepted request and updates the table
	function automatic void cache_model_step(request_t r);
		int s;
		int popped;
		int batch;
		int victim;
		logic [1:0] ns;
		logic [63:0] vk;
		case (r.rtype)
			REQ_LOOKUP: begin
				s = find_key(r.key);
				if (s >= 0) begin
					if (tbl_stat[s] == ST_PROMOTED) lru_to_top(s);
					push_answer(tbl_stat[s], '0, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < eff_active(); i++)
						if (s < 0 && tbl_stat[i] == ST_FREE) s = i;
					if (s >= 0) begin
						tbl_key[s] = r.key;
						tbl_stat[s] = ST_PROMOTING;
						push_answer(ST_FREE, '0, 1'b0, 1'b1);
					end else begin
						push_answer(ST_SKIP, '0, 1'b0, 1'b1);
					end
				end
			end
			REQ_SET_STATUS, REQ_EVICT: begin
				ns = (r.rtype == REQ_EVICT) ? ST_FREE : r.nstat;
				s = find_key(r.key);
				if (s >= 0) begin
					if (tbl_stat[s] == ST_PROMOTING && ns == ST_PROMOTED) begin
						lru_to_top(s);
						tbl_stat[s] = ST_PROMOTED;
					end else if (ns == ST_FREE) begin
						lru_drop(s);
						tbl_stat[s] = ST_FREE;
						tbl_key[s] = '0;
					end
				end
				s = find_key(r.key);
				push_answer(s >= 0 ? tbl_stat[s] : ST_FREE, '0, 1'b0, 1'b1);
			end
			REQ_EVICT_LIST: begin
				popped = 0;
				batch = (m_batch > MAX_POP) ? MAX_POP : m_batch;
				if (free_slots() * 256 < m_wmark * eff_active()) begin
					for (int i = 0; i < batch; i++) begin
						if (lru_count == 0) break;
						victim = -1;
						for (int j = 0; j < SLOTS; j++)
							if (tbl_in_lru[j] && tbl_rank[j] == lru_count - 1) victim = j;
						lru_drop(victim);
						vk = tbl_key[victim];
						push_answer(ST_FREE, vk, 1'b1, 1'b0);
						popped++;
					end
				end
				if (popped == 0) push_answer(ST_FREE, '0, 1'b0, 1'b1);
				else expected_answers[$].last = 1'b1;
			end
			REQ_QUERY: begin
				s = find_key(r.key);
				push_answer(s >= 0 ? tbl_stat[s] : ST_FREE, '0, 1'b0, 1'b1);
			end
			default: push_answer(ST_FREE, '0, 1'b0, 1'b1);
		endcase
	endfunction

	// driver: new item at the falling edge once the previous one was taken
	bit req_taken;
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 25)) begin
				request_t r;
				r = pending_reqs[0];
				pending_reqs.delete(0);
				req_ch.valid <= 1'b1;
				req_ch.req_type <= r.rtype;
				req_ch.object_key <= r.key;
				req_ch.next_status <= r.nstat;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		req_taken = 1'b0;
		rsp_ch.ready <= no_idle || $urandom_range(99) >= 25;
	end

	// monitor: predicts on accepted requests, checks accepted answers
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (req_ch.valid && req_ch.ready) begin
				request_t r;
				r.rtype = req_ch.req_type;
				r.key = req_ch.object_key;
				r.nstat = req_ch.next_status;
				req_taken = 1'b1;
				accepted_reqs++;
				cache_model_step(r);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_answers.size() == 0) begin
					$error("answer with none expected");
					errors++;
				end else begin
					answer_t e;
					e = expected_answers[0];
					expected_answers.delete(0);
					checked_answers++;
					if (rsp_ch.victim_valid) victims_seen++;
					if (rsp_ch.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.victim_key !== e.victim_key) begin
						$error("victim_key: expected %h, got %h", e.victim_key, rsp_ch.victim_key);
						errors++;
					end
					if (rsp_ch.victim_valid !== e.victim_valid) begin
						$error("victim_valid: expected %0d, got %0d", e.victim_valid,
							rsp_ch.victim_valid);
						errors++;
					end
					if (rsp_ch.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, rsp_ch.last);
						errors++;
					end
					if (rsp_ch.free_count !== e.free_count) begin
						$error("free_count: expected %0d, got %0d", e.free_count,
							rsp_ch.free_count);
						errors++;
					end
					if (rsp_ch.promoted_count !== e.promoted_count) begin
						$error("promoted_count: expected %0d, got %0d", e.promoted_count,
							rsp_ch.promoted_count);
						errors++;
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ACTIVE_ENTRIES: m_active = val[6:0];
			CFG_WATERMARK: m_wmark = val;
			CFG_EVICT_BATCH: m_batch = val[6:0];
			default: ;
		endcase
	endtask

	task automatic add_req(logic [2:0] t, logic [63:0] k, logic [1:0] ns);
		request_t r;
		r.rtype = t;
		r.key = k;
		r.nstat = ns;
		pending_reqs = {pending_reqs, r};
	endtask

	// wait for every queued item and answer, then let the block settle
	task automatic drain();
		while (pending_reqs.size() > 0 || expected_answers.size() > 0 || req_ch.valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly lookup / promote / hit sequences on a small key set, plus noise
	task automatic random_phase(int n, int pool_size);
		logic [63:0] pool[$];
		logic [63:0] k;
		int p;
		for (int i = 0; i < pool_size; i++) begin
			k = {$urandom, $urandom};
			pool = {pool, k};
		end
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(9) == 0) ? {$urandom, $urandom} :
				pool[$urandom_range(pool_size - 1)];
			p = $urandom_range(99);
			if (p < 35) add_req(REQ_LOOKUP, k, 2'($urandom));
			else if (p < 60) add_req(REQ_SET_STATUS, k,
				($urandom_range(3) == 0) ? 2'($urandom) : ST_PROMOTED);
			else if (p < 68) add_req(REQ_EVICT, k, 2'($urandom));
			else if (p < 85) add_req(REQ_EVICT_LIST, k, 2'($urandom));
			else if (p < 95) add_req(REQ_QUERY, k, 2'($urandom));
			else add_req(3'($urandom_range(7, 5)), k, 2'($urandom));
		end
	endtask

	initial begin
		logic [63:0] ka;
		logic [63:0] kb;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.object_key = '0;
		req_ch.next_status = '0;
		rsp_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		accepted_reqs = 0;
		checked_answers = 0;
		victims_seen = 0;
		no_idle = 1'b0;
		req_taken = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i] = '0;
			tbl_stat[i] = ST_FREE;
			tbl_rank[i] = 0;
			tbl_in_lru[i] = 1'b0;
		end
		lru_count = 0;
		m_active = ACTIVE_RST;
		m_wmark = WMARK_RST;
		m_batch = BATCH_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extreme keys, every request type, illegal transitions
		ka = '0;
		kb = '1;
		add_req(REQ_LOOKUP, ka, ST_FREE);
		add_req(REQ_LOOKUP, kb, 2'd3);
		add_req(REQ_QUERY, ka, ST_FREE);
		add_req(REQ_SET_STATUS, ka, ST_PROMOTED);
		add_req(REQ_SET_STATUS, kb, ST_PROMOTED);
		add_req(REQ_LOOKUP, ka, ST_FREE);
		add_req(REQ_SET_STATUS, ka, ST_PROMOTING);
		add_req(REQ_SET_STATUS, kb, 2'd3);
		add_req(REQ_SET_STATUS, 64'h5a5a_1234_0000_ffff, ST_PROMOTED);
		add_req(REQ_EVICT_LIST, ka, ST_FREE);
		add_req(REQ_EVICT, 64'h0123_4567_89ab_cdef, ST_PROMOTED);
		add_req(3'd5, kb, ST_FREE);
		add_req(3'd7, ka, 2'd3);
		add_req(REQ_LOOKUP, 64'h8000_0000_0000_0001, ST_FREE);
		add_req(REQ_SET_STATUS, 64'h8000_0000_0000_0001, ST_FREE);
		add_req(REQ_EVICT, kb, ST_FREE);
		add_req(REQ_QUERY, kb, ST_FREE);
		drain();

		// tiny table: skip on full, pops one at a time
		write_reg(CFG_ACTIVE_ENTRIES, 9'd2);
		write_reg(CFG_WATERMARK, 9'd256);
		write_reg(CFG_EVICT_BATCH, 9'd1);
		add_req(REQ_LOOKUP, 64'h1111, ST_FREE);
		add_req(REQ_LOOKUP, 64'h2222, ST_FREE);
		add_req(REQ_LOOKUP, 64'h3333, ST_FREE);
		add_req(REQ_SET_STATUS, 64'h1111, ST_PROMOTED);
		add_req(REQ_SET_STATUS, 64'h2222, ST_PROMOTED);
		add_req(REQ_LOOKUP, 64'h1111, ST_FREE);
		add_req(REQ_EVICT_LIST, '0, ST_FREE);
		add_req(REQ_LOOKUP, 64'h2222, ST_FREE);
		random_phase(40, 4);
		drain();

		// out-of-range register values
		write_reg(CFG_ACTIVE_ENTRIES, 9'd127);
		write_reg(CFG_WATERMARK, 9'd511);
		write_reg(CFG_EVICT_BATCH, 9'd127);
		random_phase(40, 24);
		drain();

		write_reg(CFG_ACTIVE_ENTRIES, 9'd0);
		write_reg(CFG_WATERMARK, 9'd0);
		write_reg(CFG_EVICT_BATCH, 9'd0);
		random_phase(30, 3);
		drain();

		// no idling on either side here
		no_idle = 1'b1;
		write_reg(CFG_ACTIVE_ENTRIES, 9'd8);
		write_reg(CFG_WATERMARK, 9'd128);
		write_reg(CFG_EVICT_BATCH, 9'd64);
		random_phase(120, 12);
		drain();
		no_idle = 1'b0;

		write_reg(CFG_ACTIVE_ENTRIES, 9'd16);
		write_reg(CFG_WATERMARK, 9'd200);
		write_reg(CFG_EVICT_BATCH, 9'd3);
		random_phase(120, 22);
		drain();

		$display("covered %0d requests, %0d answers checked, %0d victims popped",
			accepted_reqs, checked_answers, victims_seen);
		$display("register settings from the table extremes through out-of-range values");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
